// ----- design/prw_pkg.sv -----
package prw_pkg;

    // Event kinds carried in the input tuser field.
    typedef enum logic [2:0] {
        REQ_READ      = 3'd0,
        REQ_WRITE     = 3'd1,
        REQ_TICK      = 3'd2,
        REQ_INIT      = 3'd3,
        REQ_POWERFAIL = 3'd4,
        REQ_ROM_LOAD  = 3'd5
    } req_t;

    // Words per ROM page and the word-offset width inside one window.
    localparam int PAGE_WORDS = 128;
    localparam int WORD_W     = $clog2(PAGE_WORDS);

    // Register addresses (exact word addresses).
    localparam logic [15:0] A_PAGE_CTRL = 16'o177520;
    localparam logic [15:0] A_SCRATCH   = 16'o177522;
    localparam logic [15:0] A_SWITCH    = 16'o177524;
    localparam logic [15:0] A_CLOCK     = 16'o177546;

    // Window bounds.
    localparam logic [15:0] A_LOW_WIN  = 16'o173000;
    localparam logic [15:0] A_HIGH_WIN = 16'o173400;
    localparam logic [15:0] A_WIN_END  = 16'o173776;

    // Fill words for a page beyond the ROM and the clock enable bit.
    localparam logic [15:0] LOW_FILL     = 16'o177777;
    localparam logic [15:0] HIGH_FILL    = 16'o000233;
    localparam logic [15:0] CLOCK_IE_BIT = 16'o000100;
    localparam int          CLOCK_IE_POS = 6;

    // Bus status codes.
    localparam logic ST_OK  = 1'b0;
    localparam logic ST_NXM = 1'b1;

endpackage

// ----- design/prw_ram.sv -----
module prw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port; rdata holds between reads.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/paged_rom_window_with_line_clock.sv -----
// Channel  | Signals                          | Contents
// ---------+----------------------------------+-------------------------------------------
// input    | s_tvalid s_tready s_tdata s_tuser | tuser: event kind; tdata: address, write data,
//          |                                  |   ROM index, ROM data
// result   | m_tvalid m_tready m_tdata        | read data, status, selected, irq, display
// config   | cfg_valid cfg_ready cfg_data     | switch register
//
// One item is accepted per clock unless the input stalls; each result passes through
// the read stage and the output register. Registers are updated at the accept edge; a
// window read uses the ROM's registered read port; a ROM load writes the ROM at its accept edge.
// A stalled result sits in the output register while one more item waits in the
// ROM read stage; input ready drops only when both are full.
// rst_n clears the control registers and valid flags; the ROM contents are not cleared.
module paged_rom_window_with_line_clock
    import prw_pkg::*;
#(
    parameter int ROM_PAGES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // address[15:0], write_data[31:16], rom_index[42:32],
                                   // rom_data[58:43], zero[63:59]
    input  logic [2:0]  s_tuser,   // req_type[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // read_data[15:0], status[16], selected[17],
                                   // irq_request[18], display_value[34:19], zero[39:35]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int ROM_DEPTH = ROM_PAGES * PAGE_WORDS;
    localparam int ADDR_W    = $clog2(ROM_DEPTH);
    localparam int PAGE_W    = ADDR_W - WORD_W;

    // Input fields.
    logic [15:0] address;
    logic [15:0] write_data;
    logic [10:0] rom_index;
    logic [15:0] rom_data;
    req_t        req;

    assign address    = s_tdata[15:0];
    assign write_data = s_tdata[31:16];
    assign rom_index  = s_tdata[42:32];
    assign rom_data   = s_tdata[58:43];
    assign req        = req_t'(s_tuser);

    // Block state.
    logic [15:0] switch_reg;
    logic [15:0] page_control_reg, page_control_next;
    logic [15:0] scratch_reg, scratch_next;
    logic [15:0] display_reg, display_next;
    logic        clock_enable_reg, clock_enable_next;
    logic        irq_pending_reg, irq_pending_next;

    // Read stage and output register.
    logic        p1_valid_reg;
    logic [15:0] p1_rdata_reg;
    logic        p1_rom_reg;
    logic        p1_status_reg;
    logic        p1_sel_reg;
    logic        p1_irq_reg;
    logic [15:0] p1_disp_reg;

    logic        out_valid_reg;
    logic [15:0] out_rdata_reg;
    logic        out_status_reg;
    logic        out_sel_reg;
    logic        out_irq_reg;
    logic [15:0] out_disp_reg;

    logic        s_accept;
    logic        p1_adv;

    // Per-item decode.
    logic              sel;
    logic              status;
    logic [15:0]       rdata_imm;
    logic              rom_rd;
    logic [ADDR_W-1:0] rom_raddr;
    logic              rom_we;
    logic              in_low_win;
    logic              in_high_win;
    logic [7:0]        page_sel;
    logic [15:0]       clock_word;

    logic [15:0]       rom_rdata;

    // Handshakes.
    assign p1_adv    = p1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !p1_valid_reg || p1_adv;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Address decode and read data.
    always_comb
    begin
        in_low_win  = (address >= A_LOW_WIN) && (address < A_HIGH_WIN);
        in_high_win = (address >= A_HIGH_WIN) && (address <= A_WIN_END);
        page_sel    = in_high_win ? page_control_reg[15:8] : page_control_reg[7:0];
        rom_raddr   = {page_sel[PAGE_W-1:0], address[WORD_W:1]};
        clock_word  = clock_enable_reg ? CLOCK_IE_BIT : 16'd0;
        sel         = 1'b0;
        status      = ST_OK;
        rdata_imm   = 16'd0;
        rom_rd      = 1'b0;
        if (req == REQ_READ || req == REQ_WRITE)
        begin
            sel = ({address[15:1], 1'b0} == A_PAGE_CTRL) ||
                  ({address[15:1], 1'b0} == A_SCRATCH) ||
                  ({address[15:1], 1'b0} == A_SWITCH) ||
                  ({address[15:1], 1'b0} == A_CLOCK) ||
                  in_low_win || in_high_win;
        end
        if (req == REQ_READ)
        begin
            if (address == A_PAGE_CTRL)
            begin
                rdata_imm = page_control_reg;
            end
            else if (address == A_SCRATCH)
            begin
                rdata_imm = scratch_reg;
            end
            else if (address == A_SWITCH)
            begin
                rdata_imm = switch_reg;
            end
            else if (address == A_CLOCK)
            begin
                rdata_imm = clock_word;
            end
            else if (in_low_win || in_high_win)
            begin
                if (page_sel >= 8'(ROM_PAGES))
                begin
                    rdata_imm = in_high_win ? HIGH_FILL : LOW_FILL;
                end
                else
                begin
                    rom_rd = 1'b1;
                end
            end
            else
            begin
                status = ST_NXM;
            end
        end
    end

    assign rom_we = s_accept && (req == REQ_ROM_LOAD) && ({1'b0, rom_index} < 12'(ROM_DEPTH));

    // Register updates for the accepted event.
    always_comb
    begin
        page_control_next = page_control_reg;
        scratch_next      = scratch_reg;
        display_next      = display_reg;
        clock_enable_next = clock_enable_reg;
        irq_pending_next  = irq_pending_reg;
        case (req)
            REQ_WRITE:
            begin
                if (address == A_PAGE_CTRL)
                begin
                    page_control_next = write_data;
                end
                else if (address == A_SCRATCH)
                begin
                    scratch_next = write_data;
                end
                else if (address == A_SWITCH)
                begin
                    display_next = write_data;
                end
                else if (address == A_CLOCK)
                begin
                    clock_enable_next = write_data[CLOCK_IE_POS];
                end
            end
            REQ_TICK:
            begin
                irq_pending_next = clock_enable_reg;
            end
            REQ_INIT:
            begin
                page_control_next = 16'd0;
                scratch_next      = 16'd0;
                display_next      = 16'd0;
                clock_enable_next = 1'b0;
                irq_pending_next  = 1'b0;
            end
            REQ_POWERFAIL:
            begin
                clock_enable_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            switch_reg       <= 16'd0;
            page_control_reg <= 16'd0;
            scratch_reg      <= 16'd0;
            display_reg      <= 16'd0;
            clock_enable_reg <= 1'b0;
            irq_pending_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                switch_reg <= cfg_data;
            end
            if (s_accept)
            begin
                page_control_reg <= page_control_next;
                scratch_reg      <= scratch_next;
                display_reg      <= display_next;
                clock_enable_reg <= clock_enable_next;
                irq_pending_reg  <= irq_pending_next;
            end
        end
    end

    // ROM store.
    prw_ram #(
        .WIDTH (16),
        .DEPTH (ROM_DEPTH)
    ) u_rom (
        .clk   (clk),
        .we    (rom_we),
        .waddr (rom_index[ADDR_W-1:0]),
        .wdata (rom_data),
        .re    (s_accept && rom_rd),
        .raddr (rom_raddr),
        .rdata (rom_rdata)
    );

    // Valid flags of the read stage and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                p1_valid_reg <= 1'b1;
            end
            else if (p1_adv)
            begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the read stage and the output register.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            p1_rdata_reg  <= rdata_imm;
            p1_rom_reg    <= rom_rd;
            p1_status_reg <= status;
            p1_sel_reg    <= sel;
            p1_irq_reg    <= irq_pending_next;
            p1_disp_reg   <= display_next;
        end
        if (p1_adv)
        begin
            out_rdata_reg  <= p1_rom_reg ? rom_rdata : p1_rdata_reg;
            out_status_reg <= p1_status_reg;
            out_sel_reg    <= p1_sel_reg;
            out_irq_reg    <= p1_irq_reg;
            out_disp_reg   <= p1_disp_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_disp_reg, out_irq_reg, out_sel_reg, out_status_reg,
                       out_rdata_reg};

    // Bus init leaves the control registers cleared.
    a_init_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && req == REQ_INIT |=> page_control_reg == 16'd0 && !clock_enable_reg
            && !irq_pending_reg)
        else $error("bus init did not clear the registers");

    // Power fail drops the clock enable.
    a_powerfail: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && req == REQ_POWERFAIL |=> !clock_enable_reg)
        else $error("power fail left the clock enable set");

    // A tick copies the enable into the pending interrupt.
    a_tick: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && req == REQ_TICK |=> irq_pending_reg == $past(clock_enable_reg))
        else $error("tick did not follow the clock enable");

    // Input stalls only when both stages hold a waiting result.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> p1_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled with room in the pipeline");

endmodule

// ----- tb/tb_paged_rom_window_with_line_clock.sv -----
module tb_paged_rom_window_with_line_clock;
    timeunit 1ns;
    timeprecision 1ps;

    import prw_pkg::*;

    localparam int ROM_PAGES      = 16;
    localparam int ROM_DEPTH      = ROM_PAGES * PAGE_WORDS;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int IDLE_PCT       = 37;

    // Event codes that the block must ignore.
    localparam logic [2:0] REQ_SPARE6 = 3'd6;
    localparam logic [2:0] REQ_SPARE7 = 3'd7;

    typedef struct packed {
        logic [2:0]  req;
        logic [15:0] address;
        logic [15:0] write_data;
        logic [10:0] rom_index;
        logic [15:0] rom_data;
    } bus_event_t;

    typedef struct {
        logic [15:0] read_data;
        logic        status;
        logic        selected;
        logic        irq_request;
        logic [15:0] display_value;
    } bus_reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    // Shadow copy of the block state.
    logic [15:0] pg_ctrl;
    logic [15:0] scratch;
    logic [15:0] display;
    logic        clk_en;
    logic        irq_pend;
    logic [15:0] switch_reg;
    logic [15:0] rom_image [ROM_DEPTH];
    bit          rom_loaded [ROM_DEPTH];

    bus_reply_t expected_replies [$];
    int         error_count = 0;
    int         idle_pct = IDLE_PCT;
    int         hold_request = 0;

    paged_rom_window_with_line_clock #(
        .ROM_PAGES(ROM_PAGES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Index of the ROM word seen at a window address, or -1 when the page lies beyond the ROM
    // or the address is outside both windows.
    function automatic int window_index(logic [15:0] a);
        logic [7:0] page;
        if (a >= A_LOW_WIN && a < A_HIGH_WIN)
            page = pg_ctrl[7:0];
        else if (a >= A_HIGH_WIN && a <= A_WIN_END)
            page = pg_ctrl[15:8];
        else
            return -1;
        if (page >= ROM_PAGES)
            return -1;
        return int'(page) * PAGE_WORDS + int'((a >> 1) % PAGE_WORDS);
    endfunction

    // Applies one event to the shadow state and returns the reply it causes.
    function automatic bus_reply_t apply_event(bus_event_t ev);
        bus_reply_t  r;
        logic [15:0] a;
        logic [15:0] w;
        int          idx;
        a = ev.address;
        w = a & 16'hFFFE;
        r.read_data = '0;
        r.status    = ST_OK;
        r.selected  = 1'b0;
        if (ev.req == REQ_READ || ev.req == REQ_WRITE)
            r.selected = (w == A_PAGE_CTRL || w == A_SCRATCH || w == A_SWITCH
                          || w == A_CLOCK || (a >= A_LOW_WIN && a <= A_WIN_END));
        case (ev.req)
            REQ_READ:
            begin
                if (a == A_PAGE_CTRL)
                    r.read_data = pg_ctrl;
                else if (a == A_SCRATCH)
                    r.read_data = scratch;
                else if (a == A_SWITCH)
                    r.read_data = switch_reg;
                else if (a == A_CLOCK)
                    r.read_data = clk_en ? CLOCK_IE_BIT : 16'h0000;
                else if (a >= A_LOW_WIN && a <= A_WIN_END)
                begin
                    idx = window_index(a);
                    if (idx >= 0)
                        r.read_data = rom_image[idx];
                    else
                        r.read_data = (a < A_HIGH_WIN) ? LOW_FILL : HIGH_FILL;
                end
                else
                    r.status = ST_NXM;
            end
            REQ_WRITE:
            begin
                if (a == A_PAGE_CTRL)
                    pg_ctrl = ev.write_data;
                else if (a == A_SCRATCH)
                    scratch = ev.write_data;
                else if (a == A_SWITCH)
                    display = ev.write_data;
                else if (a == A_CLOCK)
                    clk_en = ev.write_data[CLOCK_IE_POS];
            end
            REQ_TICK:
                irq_pend = clk_en;
            REQ_INIT:
            begin
                pg_ctrl  = '0;
                scratch  = '0;
                display  = '0;
                clk_en   = 1'b0;
                irq_pend = 1'b0;
            end
            REQ_POWERFAIL:
                clk_en = 1'b0;
            REQ_ROM_LOAD:
            begin
                if (ev.rom_index < ROM_DEPTH)
                begin
                    rom_image[ev.rom_index]  = ev.rom_data;
                    rom_loaded[ev.rom_index] = 1'b1;
                end
            end
            default:
                ;
        endcase
        r.irq_request   = irq_pend;
        r.display_value = display;
        return r;
    endfunction

    function automatic bus_event_t mk_event(logic [2:0] req, logic [15:0] a, logic [15:0] wd,
                                            logic [10:0] ri, logic [15:0] rd);
        bus_event_t ev;
        ev.req        = req;
        ev.address    = a;
        ev.write_data = wd;
        ev.rom_index  = ri;
        ev.rom_data   = rd;
        return ev;
    endfunction

    // Mostly the first few ROM pages, sometimes any page number.
    function automatic logic [7:0] pick_page();
        if ($urandom_range(7) == 0)
            return 8'($urandom);
        return 8'($urandom_range(3));
    endfunction

    // Random event weighted toward mapped addresses and loaded ROM pages.
    function automatic bus_event_t random_event();
        bus_event_t ev;
        int         pick;
        int         idx;
        ev.address    = 16'($urandom);
        ev.write_data = 16'($urandom);
        ev.rom_index  = 11'($urandom);
        ev.rom_data   = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 35)
            ev.req = REQ_READ;
        else if (pick < 60)
            ev.req = REQ_WRITE;
        else if (pick < 70)
            ev.req = REQ_TICK;
        else if (pick < 73)
            ev.req = REQ_INIT;
        else if (pick < 77)
            ev.req = REQ_POWERFAIL;
        else if (pick < 95)
            ev.req = REQ_ROM_LOAD;
        else if (pick < 97)
            ev.req = REQ_SPARE6;
        else
            ev.req = REQ_SPARE7;

        if (ev.req == REQ_READ || ev.req == REQ_WRITE)
        begin
            pick = $urandom_range(9);
            if (pick < 4)
            begin
                case ($urandom_range(3))
                    0: ev.address = A_PAGE_CTRL;
                    1: ev.address = A_SCRATCH;
                    2: ev.address = A_SWITCH;
                    default: ev.address = A_CLOCK;
                endcase
                if (pick == 3)
                    ev.address[0] = 1'b1;
            end
            else if (pick < 8)
                ev.address = A_LOW_WIN + 16'($urandom_range(511));
        end
        if (ev.req == REQ_WRITE && ev.address == A_PAGE_CTRL && $urandom_range(3) != 0)
            ev.write_data = {pick_page(), pick_page()};
        if (ev.req == REQ_ROM_LOAD && $urandom_range(9) < 7)
            ev.rom_index = 11'($urandom_range(4 * PAGE_WORDS - 1));

        // A window word that was never loaded must not be read: load it instead.
        if (ev.req == REQ_READ)
        begin
            idx = window_index(ev.address);
            if (idx >= 0 && !rom_loaded[idx])
            begin
                ev.req       = REQ_ROM_LOAD;
                ev.rom_index = 11'(idx);
            end
        end
        return ev;
    endfunction

    // Offers one event on the input stream and records its reply once accepted.
    task automatic send_item(input bus_event_t ev);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ev.req;
        s_tdata  <= {5'b0, ev.rom_data, ev.rom_index, ev.write_data, ev.address};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_replies.push_back(apply_event(ev));
    endtask

    // Stops offering items and waits until every reply is back.
    task automatic drain_replies();
        s_tvalid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes the switch register while the block is idle.
    task automatic set_switch(input logic [15:0] value);
        drain_replies();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        switch_reg = value;
    endtask

    task automatic test_register_access();
        send_item(mk_event(REQ_READ, A_PAGE_CTRL, 16'h0000, 11'd0, 16'h0000));
        send_item(mk_event(REQ_READ, A_SWITCH, 16'h0000, 11'd0, 16'h0000));
        send_item(mk_event(REQ_WRITE, A_SCRATCH, 16'hFFFF, 11'd0, 16'h0000));
        send_item(mk_event(REQ_READ, A_SCRATCH, 16'h0000, 11'd0, 16'h0000));
        send_item(mk_event(REQ_WRITE, A_SWITCH, 16'hFFFF, 11'd0, 16'h0000));
        // Odd register addresses: the write is dropped, the read is non-existent.
        send_item(mk_event(REQ_WRITE, A_SWITCH | 16'h1, 16'h0000, 11'd0, 16'h0000));
        send_item(mk_event(REQ_READ, A_SCRATCH | 16'h1, 16'h0000, 11'd0, 16'h0000));
        // Line clock: enable, tick, power fail, tick again.
        send_item(mk_event(REQ_WRITE, A_CLOCK, CLOCK_IE_BIT, 11'd0, 16'h0000));
        send_item(mk_event(REQ_READ, A_CLOCK, 16'h0000, 11'd0, 16'h0000));
        send_item(mk_event(REQ_TICK, 16'h0000, 16'h0000, 11'd0, 16'h0000));
        send_item(mk_event(REQ_POWERFAIL, 16'h0000, 16'h0000, 11'd0, 16'h0000));
        send_item(mk_event(REQ_READ, A_CLOCK, 16'h0000, 11'd0, 16'h0000));
        send_item(mk_event(REQ_TICK, 16'hFFFF, 16'hFFFF, 11'h7FF, 16'hFFFF));
        send_item(mk_event(REQ_WRITE, A_CLOCK, ~CLOCK_IE_BIT, 11'd0, 16'h0000));
        send_item(mk_event(REQ_INIT, 16'h0000, 16'h0000, 11'd0, 16'h0000));
        send_item(mk_event(REQ_READ, A_SCRATCH, 16'h0000, 11'd0, 16'h0000));
    endtask

    task automatic test_rom_windows();
        send_item(mk_event(REQ_ROM_LOAD, 16'h0000, 16'h0000, 11'd0, 16'hFFFF));
        send_item(mk_event(REQ_ROM_LOAD, 16'h0000, 16'h0000, 11'h7FF, 16'h8001));
        send_item(mk_event(REQ_WRITE, A_PAGE_CTRL, 16'h0F00, 11'd0, 16'h0000));
        send_item(mk_event(REQ_READ, A_LOW_WIN, 16'h0000, 11'd0, 16'h0000));
        send_item(mk_event(REQ_READ, A_WIN_END, 16'h0000, 11'd0, 16'h0000));
        // Just past the high window: not selected.
        send_item(mk_event(REQ_READ, A_WIN_END | 16'h1, 16'h0000, 11'd0, 16'h0000));
        send_item(mk_event(REQ_WRITE, A_LOW_WIN, 16'h0000, 11'd0, 16'h0000));
        // Pages beyond the ROM read the fill words.
        send_item(mk_event(REQ_WRITE, A_PAGE_CTRL, 16'hFF10, 11'd0, 16'h0000));
        send_item(mk_event(REQ_READ, A_LOW_WIN, 16'h0000, 11'd0, 16'h0000));
        send_item(mk_event(REQ_READ, A_HIGH_WIN, 16'h0000, 11'd0, 16'h0000));
        send_item(mk_event(REQ_READ, 16'h0000, 16'h0000, 11'd0, 16'h0000));
        send_item(mk_event(REQ_READ, 16'hFFFF, 16'h0000, 11'd0, 16'h0000));
        send_item(mk_event(REQ_SPARE6, A_SCRATCH, 16'hFFFF, 11'h7FF, 16'hFFFF));
        send_item(mk_event(REQ_SPARE7, A_PAGE_CTRL, 16'hFFFF, 11'h7FF, 16'hFFFF));
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_item(random_event());
    endtask

    // Back-to-back traffic with no idle cycles on either side.
    task automatic test_streaming(input int count);
        idle_pct = 0;
        repeat (count) send_item(random_event());
        idle_pct = IDLE_PCT;
    endtask

    // The receiver holds off while items keep coming, so the input stalls.
    task automatic test_backpressure(input int count);
        idle_pct     = 0;
        hold_request = 200;
        repeat (count) send_item(random_event());
        idle_pct = IDLE_PCT;
    endtask

    // Result-side ready: random idling, or a long hold when one is requested.
    always @(posedge clk)
    begin : drive_result_ready
        int hold_left;
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else
            m_tready <= ($urandom_range(99) >= idle_pct);
    end

    // Compares every accepted result with the oldest expected reply.
    always @(posedge clk)
    begin : check_replies
        bus_reply_t got;
        bus_reply_t want;
        if (m_tvalid && m_tready)
        begin
            got.read_data     = m_tdata[15:0];
            got.status        = m_tdata[16];
            got.selected      = m_tdata[17];
            got.irq_request   = m_tdata[18];
            got.display_value = m_tdata[34:19];
            if (expected_replies.size() == 0)
            begin
                $error("unexpected result transaction: %h", m_tdata);
                error_count++;
            end
            else
            begin
                want = expected_replies.pop_front();
                if (got.read_data !== want.read_data)
                begin
                    $error("read_data: expected %h, got %h", want.read_data, got.read_data);
                    error_count++;
                end
                if (got.status !== want.status)
                begin
                    $error("status: expected %b, got %b", want.status, got.status);
                    error_count++;
                end
                if (got.selected !== want.selected)
                begin
                    $error("selected: expected %b, got %b", want.selected, got.selected);
                    error_count++;
                end
                if (got.irq_request !== want.irq_request)
                begin
                    $error("irq_request: expected %b, got %b",
                           want.irq_request, got.irq_request);
                    error_count++;
                end
                if (got.display_value !== want.display_value)
                begin
                    $error("display_value: expected %h, got %h",
                           want.display_value, got.display_value);
                    error_count++;
                end
            end
        end
    end

    // Ends the run when no transaction of any kind completes for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin : run_tests
        pg_ctrl    = '0;
        scratch    = '0;
        display    = '0;
        clk_en     = 1'b0;
        irq_pend   = 1'b0;
        switch_reg = '0;
        foreach (rom_loaded[i])
        begin
            rom_loaded[i] = 1'b0;
            rom_image[i]  = '0;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_access();
        test_rom_windows();
        set_switch(16'hFFFF);
        test_random_traffic(300);
        set_switch(16'($urandom));
        test_streaming(200);
        test_backpressure(60);
        set_switch(16'h0000);
        test_random_traffic(400);

        drain_replies();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/prw_pkg.sv
design/prw_ram.sv
design/paged_rom_window_with_line_clock.sv
tb/tb_paged_rom_window_with_line_clock.sv
